// File: rtl/sltb_pkg.sv
// ----------------------------------------------------------------------------
// sltb_pkg: shared types and constants for the sorted list table
// Request/result payloads, operation and status codes, the cell command
// and the sequencer state type.
// ----------------------------------------------------------------------------
package sltb_pkg;

   localparam int DEPTH_DEFAULT = 16;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOAD,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      op_type             opcode;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [4:0]  position;
      logic [4:0]  entry_count;
      logic        is_empty;
   } rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic load;    // capture compare flags into the scan chain
      logic use_le;  // scan counts entries <= key (insert) instead of < key
      logic shift;   // move scan flags one cell toward cell 0
      logic ins_wr;  // open a slot and write the key
      logic rem_wr;  // close the gap at the first match
   } cell_cmd_type;

endpackage

// File: rtl/sltb_cell.sv
// ----------------------------------------------------------------------------
// sltb_cell: one slot of the sorted table
// Holds one entry, compares it against the broadcast key, carries one stage
// of the rank/match scan chain and shifts entries on insert and remove.
// ----------------------------------------------------------------------------
module sltb_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  sltb_pkg::cell_cmd_type cmd,
   input  logic signed [31:0]    key,
   input  logic                  occupied,
   input  logic signed [31:0]    left_entry,
   input  logic                  left_le,
   input  logic signed [31:0]    right_entry,
   input  logic                  right_rank,
   input  logic                  right_match,
   output logic signed [31:0]    entry,
   output logic                  le,
   output logic                  rank_flag,
   output logic                  match_flag
);

   logic signed [31:0] entry_ff, entry_in;
   logic               rank_ff, rank_in;
   logic               match_ff, match_in;
   logic               lt;
   logic               eq;

   assign lt = occupied && (entry_ff < key);
   assign le = occupied && (entry_ff <= key);
   assign eq = occupied && (entry_ff == key);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins_wr && !le) begin
         // first cell past the insertion point takes the key
         entry_in = left_le ? key : left_entry;
      end else if (cmd.rem_wr && !lt) begin
         entry_in = right_entry;
      end
   end

   always_comb begin
      rank_in  = rank_ff;
      match_in = match_ff;
      if (cmd.load) begin
         rank_in  = cmd.use_le ? le : lt;
         match_in = eq;
      end else if (cmd.shift) begin
         rank_in  = right_rank;
         match_in = right_match;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff  <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         rank_ff  <= rank_in;
         match_ff <= match_in;
      end
   end

   assign entry      = entry_ff;
   assign rank_flag  = rank_ff;
   assign match_flag = match_ff;

endmodule

// File: rtl/sltb_ctrl.sv
// ----------------------------------------------------------------------------
// sltb_ctrl: request sequencer for the sorted table
// Latches a request, runs the rank/match scan out of the cell chain, then
// commits the update, the entry count and the result register.
// ----------------------------------------------------------------------------
module sltb_ctrl #(
   parameter int DEPTH = sltb_pkg::DEPTH_DEFAULT,
   localparam int CW   = $clog2(DEPTH + 1),
   localparam int SW   = $clog2(DEPTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sltb_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sltb_pkg::rsp_type      rsp_data,
   input  logic                   head_rank,
   input  logic                   head_match,
   output sltb_pkg::cell_cmd_type cmd,
   output logic signed [31:0]     key,
   output logic [CW-1:0]          count
);

   localparam int OW = (CW > 5) ? CW : 5;

   sltb_pkg::state_type state_ff, state_in;
   sltb_pkg::req_type   req_ff, req_in;
   sltb_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       rank_ff, rank_in;
   logic                found_ff, found_in;
   logic [SW-1:0]       scan_ff, scan_in;
   logic                full;
   logic                finish;
   logic [OW-1:0]       pos_wide;
   logic [OW-1:0]       cnt_wide;

   assign full = (count_ff == CW'(DEPTH));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      count_in     = count_ff;
      rank_in      = rank_ff;
      found_in     = found_ff;
      scan_in      = scan_ff;
      cmd          = '0;
      cmd.use_le   = (req_ff.opcode == sltb_pkg::OP_INSERT);
      finish       = 1'b0;
      req_stall    = (state_ff != sltb_pkg::S_IDLE);
      pos_wide     = '0;
      cnt_wide     = '0;

      unique case (state_ff)
         sltb_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = sltb_pkg::S_LOAD;
            end
         end
         sltb_pkg::S_LOAD: begin
            cmd.load = 1'b1;
            rank_in  = '0;
            found_in = 1'b0;
            scan_in  = '0;
            state_in = sltb_pkg::S_SCAN;
         end
         sltb_pkg::S_SCAN: begin
            // flags are monotone along the sorted chain, so a running sum is the rank
            cmd.shift = 1'b1;
            rank_in   = rank_ff + CW'(head_rank);
            found_in  = found_ff | head_match;
            scan_in   = scan_ff + SW'(1);
            if (scan_ff == SW'(DEPTH - 1)) begin
               state_in = sltb_pkg::S_DONE;
            end
         end
         sltb_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               finish   = 1'b1;
               state_in = sltb_pkg::S_IDLE;
               rsp_in.status = sltb_pkg::ST_OK;
               unique case (req_ff.opcode)
                  sltb_pkg::OP_INSERT: begin
                     if (full) begin
                        rsp_in.status = sltb_pkg::ST_FULL;
                     end else begin
                        cmd.ins_wr = 1'b1;
                        pos_wide   = OW'(rank_ff);
                        count_in   = count_ff + CW'(1);
                     end
                  end
                  sltb_pkg::OP_REMOVE, sltb_pkg::OP_FIND: begin
                     if (found_ff) begin
                        pos_wide = OW'(rank_ff);
                        if (req_ff.opcode == sltb_pkg::OP_REMOVE) begin
                           cmd.rem_wr = 1'b1;
                           count_in   = count_ff - CW'(1);
                        end
                     end else begin
                        rsp_in.status = sltb_pkg::ST_NOT_FOUND;
                     end
                  end
                  default: begin
                  end
               endcase
               cnt_wide             = OW'(count_in);
               rsp_in.position      = pos_wide[4:0];
               rsp_in.entry_count   = cnt_wide[4:0];
               rsp_in.is_empty      = (count_in == '0);
            end
         end
         default: begin
            state_in = sltb_pkg::S_IDLE;
         end
      endcase

      rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sltb_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         rank_ff      <= '0;
         found_ff     <= 1'b0;
         scan_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         rank_ff      <= rank_in;
         found_ff     <= found_in;
         scan_ff      <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign key       = req_ff.item_value;
   assign count     = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above table depth");

   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == sltb_pkg::S_LOAD))
      else $error("accepted transaction did not start a scan");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sltb_pkg::S_SCAN && scan_ff == SW'(DEPTH - 1))
      |=> (state_ff == sltb_pkg::S_DONE))
      else $error("scan did not end after last cell");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == sltb_pkg::S_DONE))
      else $error("result raised outside completion");

endmodule

// File: rtl/sorted_list_table_top.sv
// ----------------------------------------------------------------------------
// sorted_list_table_top: sorted table of signed 32-bit values
// Insert, remove and find over a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// After a transaction is accepted, S_LOAD captures every cell's compare against
// the key, S_SCAN shifts the compare flags out of the cell chain into the rank
// counter, and S_DONE commits the shift and writes the result register. S_DONE
// waits while an earlier result is still held under rsp_stall. A new request is
// taken only in S_IDLE, once the previous one has committed, even while its
// result still waits under rsp_stall. Position and entry_count are reported
// modulo 32. Stored values come up undefined after reset; only slots below the
// entry count are ever compared.
module sorted_list_table_top #(
   parameter int DEPTH = sltb_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sltb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sltb_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   sltb_pkg::cell_cmd_type cmd;
   logic signed [31:0]     key;
   logic [CW-1:0]          count;
   logic signed [31:0]     entry_w [DEPTH];
   logic                   le_w    [DEPTH];
   logic                   rank_w  [DEPTH];
   logic                   match_w [DEPTH];

   sltb_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .head_rank  (rank_w[0]),
      .head_match (match_w[0]),
      .cmd        (cmd),
      .key        (key),
      .count      (count)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] left_entry;
      logic               left_le;
      logic signed [31:0] right_entry;
      logic               right_rank;
      logic               right_match;

      if (i == 0) begin : g_first
         // head of the table: an insert point here always takes the key
         assign left_entry = '0;
         assign left_le    = 1'b1;
      end else begin : g_mid
         assign left_entry = entry_w[i-1];
         assign left_le    = le_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = '0;
         assign right_rank  = 1'b0;
         assign right_match = 1'b0;
      end else begin : g_inner
         assign right_entry = entry_w[i+1];
         assign right_rank  = rank_w[i+1];
         assign right_match = match_w[i+1];
      end

      sltb_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .key         (key),
         .occupied    (count > CW'(i)),
         .left_entry  (left_entry),
         .left_le     (left_le),
         .right_entry (right_entry),
         .right_rank  (right_rank),
         .right_match (right_match),
         .entry       (entry_w[i]),
         .le          (le_w[i]),
         .rank_flag   (rank_w[i]),
         .match_flag  (match_w[i])
      );
   end

endmodule
